// File: design/rlfq_pkg.sv
// ---------------------------------------------------------------------------
// rlfq_pkg
// Shared types and constants for the recursive lock with a fifo wait queue.
// ---------------------------------------------------------------------------
`default_nettype none

package rlfq_pkg;

   // default sizes of the wait queue and of a stored requester id
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_WIDTH_DEF    = 8;

   // widest requester id that the datapath supports
   localparam int ID_EXT_W = 32;

   // request word fields
   localparam int OP_W        = 2;
   localparam int REQ_ID_W    = 8;
   localparam int REQ_TDATA_W = 16;

   // response word fields
   localparam int HOLDER_ID_W = 8;
   localparam int COUNT_W     = 8;
   localparam int QLEN_W      = 5;
   localparam int RSP_TDATA_W = 32;

   // bit of holder_valid in the response word
   localparam int RSP_HOLDER_VALID_BIT = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOCK   = 2'd0;
   localparam logic [OP_W-1:0] OP_UNLOCK = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd2;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic match;
      logic update;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

// File: design/reentrant_lock_fifo_queue_unit.sv
// ---------------------------------------------------------------------------
// reentrant_lock_fifo_queue_unit
// Recursive lock with a first-in first-out wait queue; the head holds it.
//
//   channel  dir  handshake              word
//   req_     in   req_tvalid/req_tready  op, requester_id
//   rsp_     out  rsp_tvalid/rsp_tready  flags, holder, count, queue length
//
// Each request word passes three steps: capture, parallel match of the id
// against all queue entries, then update of queue, fill and nest count.
// The update waits while the previous response word is still held.
// A new request is taken while a finished response waits to be read.
// Synchronous reset empties the queue and clears the count; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module reentrant_lock_fifo_queue_unit #(
   parameter int QUEUE_DEPTH = rlfq_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH    = rlfq_pkg::ID_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // [1:0] op, [9:2] requester_id
   input  wire logic [rlfq_pkg::REQ_TDATA_W-1:0] req_tdata,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [0] granted, [1] already_waiting, [2] queue_overflow, [3] empty_unlock,
   // [4] removed, [5] holder_valid, [13:6] holder_id, [21:14] hold_count,
   // [26:22] queue_length
   output      logic [rlfq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import rlfq_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer
   rlfq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // queue and response datapath
   rlfq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: design/rlfq_datapath.sv
// ---------------------------------------------------------------------------
// rlfq_datapath
// Wait queue, nest counter, match stage, update logic and response register.
// ---------------------------------------------------------------------------
`default_nettype none

module rlfq_datapath #(
   parameter int QUEUE_DEPTH = rlfq_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH    = rlfq_pkg::ID_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire rlfq_pkg::ctrl_cmd_type             cmd,
   output      rlfq_pkg::ctrl_status_type          status,
   input  wire logic [rlfq_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [rlfq_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   import rlfq_pkg::*;

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   // captured request
   logic [OP_W-1:0]      op_ff;
   logic [ID_WIDTH-1:0]  id_ff;
   logic [ID_EXT_W-1:0]  req_id_ext;

   // queue state, entry 0 is the holder
   logic [ID_WIDTH-1:0]  queue_ff   [QUEUE_DEPTH];
   logic [ID_WIDTH-1:0]  queue_in   [QUEUE_DEPTH];
   logic [FILL_W-1:0]    fill_ff;
   logic [FILL_W-1:0]    fill_in;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;

   // match stage
   logic [QUEUE_DEPTH-1:0] match_ff;
   logic [QUEUE_DEPTH-1:0] match_in;
   logic [QUEUE_DEPTH-1:0] prefix;

   // response register
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   // update decisions
   logic                   granted;
   logic                   waiting;
   logic                   overflow;
   logic                   empty_unl;
   logic                   removed;
   logic                   enq;
   logic                   shift;
   logic [QUEUE_DEPTH-1:0] shift_mask;

   // capture request word
   assign req_id_ext = ID_EXT_W'(req_tdata[OP_W +: REQ_ID_W]);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_tdata[OP_W-1:0];
         id_ff <= req_id_ext[ID_WIDTH-1:0];
      end
   end

   // compare every live entry against the id
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         match_in[i] = (FILL_W'(i) < fill_ff) && (queue_ff[i] == id_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match) begin
         match_ff <= match_in;
      end
   end

   // entries at or after the match move down one place
   always_comb begin
      prefix[0] = match_ff[0];
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         prefix[i] = prefix[i-1] | match_ff[i];
      end
   end

   // operation decode
   always_comb begin
      logic [COUNT_W-1:0] count_dec;
      count_dec  = (count_ff != '0) ? count_ff - COUNT_W'(1) : '0;
      granted    = 1'b0;
      waiting    = 1'b0;
      overflow   = 1'b0;
      empty_unl  = 1'b0;
      removed    = 1'b0;
      enq        = 1'b0;
      shift      = 1'b0;
      shift_mask = prefix;
      count_in   = count_ff;
      case (op_ff)
         OP_LOCK: begin
            if (fill_ff == '0) begin
               enq      = 1'b1;
               count_in = COUNT_W'(1);
               granted  = 1'b1;
            end else if (match_ff[0]) begin
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               granted = 1'b1;
            end else if (|match_ff) begin
               waiting = 1'b1;
            end else if (fill_ff != FILL_W'(QUEUE_DEPTH)) begin
               enq = 1'b1;
            end else begin
               overflow = 1'b1;
            end
         end
         OP_UNLOCK: begin
            if (fill_ff == '0) begin
               empty_unl = 1'b1;
            end else begin
               count_in = count_dec;
               if (count_dec == '0) begin
                  shift      = 1'b1;
                  shift_mask = '1;
               end
            end
         end
         OP_FREE: begin
            if (match_ff[0]) begin
               count_in = '0;
            end
            if (|match_ff) begin
               shift   = 1'b1;
               removed = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // next queue contents and fill
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         queue_in[i] = queue_ff[i];
      end
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         if (shift && shift_mask[i]) begin
            queue_in[i] = queue_ff[i+1];
         end
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (enq && (FILL_W'(i) == fill_ff)) begin
            queue_in[i] = id_ff;
         end
      end
      if (enq) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (shift) begin
         fill_in = fill_ff - FILL_W'(1);
      end else begin
         fill_in = fill_ff;
      end
   end

   // queue storage, no reset: entries past the fill are never read
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            queue_ff[i] <= queue_in[i];
         end
      end
   end

   // fill and nest count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.update) begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   // response word
   always_comb begin
      logic                   holder_valid;
      logic [ID_EXT_W-1:0]    head_ext;
      logic [ID_EXT_W-1:0]    fill_ext;
      logic [HOLDER_ID_W-1:0] holder_id;
      holder_valid = (fill_in != '0);
      head_ext     = ID_EXT_W'(queue_in[0]);
      fill_ext     = ID_EXT_W'(fill_in);
      holder_id    = holder_valid ? head_ext[HOLDER_ID_W-1:0] : '0;
      rsp_data_in  = RSP_TDATA_W'({fill_ext[QLEN_W-1:0], count_in, holder_id,
                                   holder_valid, removed, empty_unl, overflow,
                                   waiting, granted});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.update) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   a_count_needs_holder: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> fill_ff != '0)
      else $error("nest count held with empty queue");

   a_update_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_tvalid)
      else $error("update did not present a response");

   a_grant_holds: assert property (@(posedge clock) disable iff (reset)
      cmd.update && granted |=> rsp_tdata[RSP_HOLDER_VALID_BIT])
      else $error("grant without a holder");

endmodule

`default_nettype wire

// File: design/rlfq_ctrl.sv
// ---------------------------------------------------------------------------
// rlfq_ctrl
// Sequencer: takes a request word, runs the match and update steps.
// ---------------------------------------------------------------------------
`default_nettype none

module rlfq_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output      logic                      req_tready,
   output      rlfq_pkg::ctrl_cmd_type    cmd,
   input  wire rlfq_pkg::ctrl_status_type status
);

   import rlfq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// File: dv/reentrant_lock_fifo_queue_unit_test.sv
// ---------------------------------------------------------------------------
// reentrant_lock_fifo_queue_unit_test
// Self-checking bench for the recursive lock with a fifo wait queue. A small
// tracker class keeps its own copy of the wait queue and nest count. It
// predicts the response word for every accepted request word and compares the
// responses field by field. Directed words cover the corner cases first. Then
// random bursts fill, drain and deeply nest the lock, with random gaps on
// both channels.
// ---------------------------------------------------------------------------
module reentrant_lock_fifo_queue_unit_test;
   import rlfq_pkg::*;

   // op code that the block must treat as a no-op
   localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

   localparam int ITEM_TARGET  = 1550;
   localparam int NEST_RUN     = 260;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 600000;

   // expected content of one response word
   typedef struct packed {
      bit                   granted;
      bit                   already_waiting;
      bit                   queue_overflow;
      bit                   empty_unlock;
      bit                   removed;
      bit                   holder_valid;
      bit [HOLDER_ID_W-1:0] holder_id;
      bit [COUNT_W-1:0]     hold_count;
      bit [QLEN_W-1:0]      queue_length;
   } lock_status_type;

   // shadow of the lock state plus the responses still owed by the block
   class lock_queue_tracker_type;
      bit [REQ_ID_W-1:0] wait_ids[$];
      bit [COUNT_W-1:0]  nest;
      lock_status_type   expected_status[$];
      int                mismatches;
      int                checked;
      int                grants;
      int                overflows;
      int                empty_unlocks;
      int                removals;
      int                saturated;

      function int find_requester(bit [REQ_ID_W-1:0] id);
         for (int i = 0; i < wait_ids.size(); i++) begin
            if (wait_ids[i] == id) return i;
         end
         return -1;
      endfunction

      function bit [REQ_ID_W-1:0] head();
         return (wait_ids.size() != 0) ? wait_ids[0] : '0;
      endfunction

      function int fill();
         return wait_ids.size();
      endfunction

      function int pending();
         return expected_status.size();
      endfunction

      // apply one accepted request word and queue the response it owes
      function void note_request(logic [OP_W-1:0] op, logic [REQ_ID_W-1:0] id);
         lock_status_type st;
         int              pos;
         st = '0;
         case (op)
            OP_LOCK: begin
               if (wait_ids.size() == 0) begin
                  wait_ids.insert(wait_ids.size(), id);
                  nest = COUNT_W'(1);
                  st.granted = 1'b1;
               end else if (wait_ids[0] == id) begin
                  if (nest != COUNT_MAX) nest++;
                  st.granted = 1'b1;
               end else if (find_requester(id) >= 0) begin
                  st.already_waiting = 1'b1;
               end else if (wait_ids.size() < QUEUE_DEPTH_DEF) begin
                  wait_ids.insert(wait_ids.size(), id);
               end else begin
                  st.queue_overflow = 1'b1;
               end
            end
            OP_UNLOCK: begin
               if (wait_ids.size() == 0) begin
                  st.empty_unlock = 1'b1;
               end else begin
                  // count clamps at zero; the head goes once it is zero
                  if (nest != 0) nest--;
                  if (nest == 0) wait_ids.delete(0);
               end
            end
            OP_FREE: begin
               if (wait_ids.size() != 0 && wait_ids[0] == id) nest = '0;
               pos = find_requester(id);
               if (pos >= 0) begin
                  wait_ids.delete(pos);
                  st.removed = 1'b1;
               end
            end
            default: begin
            end
         endcase
         st.holder_valid = (wait_ids.size() != 0);
         st.holder_id    = head();
         st.hold_count   = nest;
         st.queue_length = QLEN_W'(wait_ids.size());
         expected_status.insert(expected_status.size(), st);
      endfunction

      task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
         $display("mismatch in %s at response %0d: got 0x%0h, expected 0x%0h",
                  field, checked, got, want);
         mismatches++;
      endtask

      // compare one accepted response word with the oldest expectation
      task check_response(logic [RSP_TDATA_W-1:0] word);
         lock_status_type want;
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected response word", word, '0);
            return;
         end
         want = expected_status[0];
         expected_status.delete(0);
         checked++;
         if (word[0] !== want.granted)
            report_mismatch("granted", word[0], want.granted);
         if (word[1] !== want.already_waiting)
            report_mismatch("already_waiting", word[1], want.already_waiting);
         if (word[2] !== want.queue_overflow)
            report_mismatch("queue_overflow", word[2], want.queue_overflow);
         if (word[3] !== want.empty_unlock)
            report_mismatch("empty_unlock", word[3], want.empty_unlock);
         if (word[4] !== want.removed)
            report_mismatch("removed", word[4], want.removed);
         if (word[RSP_HOLDER_VALID_BIT] !== want.holder_valid)
            report_mismatch("holder_valid", word[RSP_HOLDER_VALID_BIT], want.holder_valid);
         if (word[13:6] !== want.holder_id)
            report_mismatch("holder_id", word[13:6], want.holder_id);
         if (word[21:14] !== want.hold_count)
            report_mismatch("hold_count", word[21:14], want.hold_count);
         if (word[26:22] !== want.queue_length)
            report_mismatch("queue_length", word[26:22], want.queue_length);
         grants        += want.granted;
         overflows     += want.queue_overflow;
         empty_unlocks += want.empty_unlock;
         removals      += want.removed;
         if (want.hold_count == COUNT_MAX) saturated++;
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   lock_queue_tracker_type tracker = new();
   int                     words_sent;
   int                     cycles;

   reentrant_lock_fifo_queue_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock, period 12
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // idle length: mostly none or short, now and then long
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // offer one request word, wait for its handshake, then maybe idle
   task send_word(input logic [OP_W-1:0] op, input logic [REQ_ID_W-1:0] id,
                  input bit steady);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W-OP_W-REQ_ID_W){1'b0}}, id, op};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(op, id);
      words_sent++;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response side back-pressure
   initial begin
      int run;
      int stall;
      while (reset) @(posedge clock);
      forever begin
         run = $urandom_range(1, 40);
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata);
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("run stopped by watchdog after %0d cycles", cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // stimulus
   initial begin
      int                  kind;
      int                  len;
      int                  r;
      int                  nest_runs;
      bit                  steady;
      bit [REQ_ID_W-1:0]   pool_base;
      logic [OP_W-1:0]     op;
      logic [REQ_ID_W-1:0] id;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corner cases
      send_word(OP_UNLOCK,  8'h3c, 1'b0);   // unlock with nobody there
      send_word(OP_LOCK,    8'h00, 1'b0);   // first grant
      send_word(OP_LOCK,    8'h00, 1'b0);   // nested grant
      send_word(OP_LOCK,    8'hff, 1'b0);   // queued behind holder
      send_word(OP_LOCK,    8'hff, 1'b0);   // already waiting
      send_word(OP_FREE,    8'h4d, 1'b0);   // free of an absent requester
      send_word(OP_UNKNOWN, 8'haa, 1'b0);   // unknown op leaves state alone
      send_word(OP_UNLOCK,  8'hc3, 1'b0);
      send_word(OP_UNLOCK,  8'h00, 1'b0);   // pop, new head with zero count
      send_word(OP_UNLOCK,  8'hff, 1'b0);   // unlock with zero count pops
      send_word(OP_LOCK,    8'h55, 1'b0);
      send_word(OP_LOCK,    8'haa, 1'b0);
      send_word(OP_LOCK,    8'h81, 1'b0);
      send_word(OP_FREE,    8'haa, 1'b0);   // free from the middle
      send_word(OP_FREE,    8'h55, 1'b0);   // free of the holder
      send_word(OP_LOCK,    8'h81, 1'b0);   // new head takes count one
      send_word(OP_FREE,    8'h81, 1'b0);   // empties the queue

      // random bursts
      pool_base = REQ_ID_W'($urandom_range(0, 255));
      nest_runs = 0;
      while (words_sent < ITEM_TARGET) begin
         kind   = $urandom_range(0, 99);
         steady = ($urandom_range(0, 3) == 0);
         if (kind >= 93 && nest_runs < 2) begin
            // deep nesting by the current holder, past the count limit
            nest_runs++;
            id = (tracker.fill() != 0) ? tracker.head() : pool_base;
            repeat (NEST_RUN) send_word(OP_LOCK, id, steady);
         end else if (kind < 45) begin
            // fill: mostly locks from a pool a bit larger than the queue
            if ($urandom_range(0, 9) < 3) pool_base = REQ_ID_W'($urandom_range(0, 255));
            len = $urandom_range(20, 60);
            repeat (len) begin
               r  = $urandom_range(0, 99);
               op = (r < 75) ? OP_LOCK : (r < 90) ? OP_UNLOCK : OP_FREE;
               id = pool_base + REQ_ID_W'($urandom_range(0, 19));
               send_word(op, id, steady);
            end
         end else if (kind < 75) begin
            // drain: unlocks and frees of queued requesters
            len = $urandom_range(10, 40);
            repeat (len) begin
               r  = $urandom_range(0, 99);
               op = (r < 55) ? OP_UNLOCK : (r < 85) ? OP_FREE : OP_LOCK;
               if (op == OP_FREE && $urandom_range(0, 9) < 4)
                  id = tracker.head();
               else if (op == OP_UNLOCK)
                  id = REQ_ID_W'($urandom_range(0, 255));
               else
                  id = pool_base + REQ_ID_W'($urandom_range(0, 19));
               send_word(op, id, steady);
            end
         end else begin
            // noise over the whole id range
            len = $urandom_range(5, 30);
            repeat (len) begin
               op = OP_W'($urandom_range(0, 2));
               id = REQ_ID_W'($urandom_range(0, 255));
               send_word(op, id, steady);
            end
         end
      end
      req_tvalid <= 1'b0;

      // let every owed response arrive, then let the bench idle before the summary
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d words, checked %0d responses: %0d grants, %0d overflow refusals",
               words_sent, tracker.checked, tracker.grants, tracker.overflows);
      $display("%0d empty unlocks, %0d removals, %0d responses at the nest limit",
               tracker.empty_unlocks, tracker.removals, tracker.saturated);
      if (tracker.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
